// ===== hdl/mtl_pkg.sv =====
// shared types, constants and sizing for the motion to light latency meter
package mtl_pkg;

   localparam int SLOTS           = 16;
   localparam int BRIGHTNESS_BITS = 10;
   localparam int TIME_W          = 32;
   localparam int CALM_W          = 8;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 32;

   localparam int HALF_SLOTS = (SLOTS + 1) / 2;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int HITS_W     = $clog2(HALF_SLOTS + 1);
   localparam int SUM_W      = TIME_W + $clog2(HALF_SLOTS);
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

   localparam logic [CALM_W-1:0]          CALM_SAMPLES_RESET = CALM_W'(50);
   localparam logic [BRIGHTNESS_BITS-1:0] THRESHOLD_RESET    = BRIGHTNESS_BITS'(3);
   localparam logic [TIME_W-1:0]          TIMEOUT_RESET      = TIME_W'(1000000);

   localparam logic [CSR_INDEX_W-1:0] CSR_CALM_SAMPLES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT      = 2'd2;

   typedef enum logic [1:0] {
      PH_CALM         = 2'd0,
      PH_AWAIT_MOTION = 2'd1,
      PH_AWAIT_BRIGHT = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_PUSH
   } ctrl_state_type;

   typedef struct packed {
      logic                       is_moving;
      logic [BRIGHTNESS_BITS-1:0] brightness;
      logic [TIME_W-1:0]          time_us;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        phase;
      logic              latency_valid;
      logic              timed_out;
      logic [TIME_W-1:0] latency_us;
      logic              averages_valid;
      logic [TIME_W-1:0] first_average_us;
      logic [TIME_W-1:0] second_average_us;
      logic              first_empty;
      logic              second_empty;
   } rsp_item_type;

   typedef struct packed {
      logic load_in;
      logic step;
      logic div_start;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic last_slot;
      logic div_busy;
   } dp_status_type;

endpackage

// ===== hdl/mtl_divider.sv =====
// bit-serial restoring divider for the slot averages
module mtl_divider import mtl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [HITS_W-1:0] divisor,
   output logic              busy,
   output logic [SUM_W-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]     quot_ff, quot_in;
   logic [HITS_W-1:0]    rem_ff, rem_in;
   logic [HITS_W-1:0]    divisor_ff, divisor_in;
   logic [HITS_W:0]      shifted;
   logic [HITS_W:0]      trial;
   logic                 fits;

   assign shifted = {rem_ff, quot_ff[SUM_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(SUM_W);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[SUM_W-2:0], fits};
         rem_in   = fits ? trial[HITS_W-1:0] : shifted[HITS_W-1:0];
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// ===== hdl/mtl_datapath.sv =====
// datapath: config registers, phase state, slot sums, dividers and result registers
module mtl_datapath import mtl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  req_item_type           req_item,
   output rsp_item_type           rsp_item
);

   logic [CALM_W-1:0]          calm_samples_ff;
   logic [BRIGHTNESS_BITS-1:0] threshold_ff;
   logic [TIME_W-1:0]          timeout_ff;

   req_item_type in_ff;

   phase_type                  phase_ff, phase_in;
   logic [CALM_W-1:0]          calm_run_ff, calm_run_in;
   logic [TIME_W-1:0]          motion_time_ff, motion_time_in;
   logic [BRIGHTNESS_BITS-1:0] ref_bright_ff, ref_bright_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [SUM_W-1:0]           first_sum_ff, first_sum_in, first_sum_upd;
   logic [SUM_W-1:0]           second_sum_ff, second_sum_in, second_sum_upd;
   logic [HITS_W-1:0]          first_hits_ff, first_hits_in, first_hits_upd;
   logic [HITS_W-1:0]          second_hits_ff, second_hits_in, second_hits_upd;

   rsp_item_type pend_ff, pend_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [CALM_W-1:0]          run_inc;
   logic [TIME_W-1:0]          elapsed;
   logic [BRIGHTNESS_BITS-1:0] diff;
   logic                       hit, tmo, record, last;
   logic                       first_busy, second_busy;
   logic [SUM_W-1:0]           first_quot, second_quot;

   assign run_inc = calm_run_ff + CALM_W'(1);
   assign elapsed = in_ff.time_us - motion_time_ff;
   assign diff    = (in_ff.brightness >= ref_bright_ff) ? in_ff.brightness - ref_bright_ff
                                                        : ref_bright_ff - in_ff.brightness;
   assign hit     = diff > threshold_ff;
   assign tmo     = !hit && (elapsed > timeout_ff);
   assign record  = (phase_ff == PH_AWAIT_BRIGHT) && (hit || tmo);
   assign last    = record && (slot_ff == SLOT_LAST);

   // running sums including this item, before any round reset
   always_comb begin
      first_sum_upd   = first_sum_ff;
      second_sum_upd  = second_sum_ff;
      first_hits_upd  = first_hits_ff;
      second_hits_upd = second_hits_ff;
      if (record && hit) begin
         if (!slot_ff[0]) begin
            first_sum_upd  = first_sum_ff + SUM_W'(elapsed);
            first_hits_upd = first_hits_ff + HITS_W'(1);
         end else begin
            second_sum_upd  = second_sum_ff + SUM_W'(elapsed);
            second_hits_upd = second_hits_ff + HITS_W'(1);
         end
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      calm_run_in    = calm_run_ff;
      motion_time_in = motion_time_ff;
      ref_bright_in  = ref_bright_ff;
      slot_in        = slot_ff;
      first_sum_in   = first_sum_ff;
      second_sum_in  = second_sum_ff;
      first_hits_in  = first_hits_ff;
      second_hits_in = second_hits_ff;
      unique case (phase_ff)
         PH_CALM: begin
            if (in_ff.is_moving) begin
               calm_run_in = '0;
            end else if (run_inc >= calm_samples_ff) begin
               phase_in    = PH_AWAIT_MOTION;
               calm_run_in = '0;
            end else begin
               calm_run_in = run_inc;
            end
         end
         PH_AWAIT_MOTION: begin
            if (in_ff.is_moving) begin
               motion_time_in = in_ff.time_us;
               ref_bright_in  = in_ff.brightness;
               phase_in       = PH_AWAIT_BRIGHT;
            end
         end
         PH_AWAIT_BRIGHT: begin
            if (record) begin
               phase_in = PH_CALM;
               if (last) begin
                  slot_in        = '0;
                  first_sum_in   = '0;
                  second_sum_in  = '0;
                  first_hits_in  = '0;
                  second_hits_in = '0;
               end else begin
                  slot_in        = slot_ff + SLOT_W'(1);
                  first_sum_in   = first_sum_upd;
                  second_sum_in  = second_sum_upd;
                  first_hits_in  = first_hits_upd;
                  second_hits_in = second_hits_upd;
               end
            end
         end
         default: begin
            phase_in = PH_CALM;
         end
      endcase
   end

   always_comb begin
      pend_in                   = pend_ff;
      if (cmd.step) begin
         pend_in.phase             = phase_in;
         pend_in.latency_valid     = record && hit;
         pend_in.timed_out         = record && tmo;
         pend_in.latency_us        = (record && hit) ? elapsed : '0;
         pend_in.averages_valid    = last;
         pend_in.first_average_us  = '0;
         pend_in.second_average_us = '0;
         pend_in.first_empty       = last && (first_hits_upd == '0);
         pend_in.second_empty      = last && (second_hits_upd == '0);
      end
   end

   always_comb begin
      rsp_in = pend_ff;
      if (pend_ff.averages_valid && !pend_ff.first_empty) begin
         rsp_in.first_average_us = first_quot[TIME_W-1:0];
      end
      if (pend_ff.averages_valid && !pend_ff.second_empty) begin
         rsp_in.second_average_us = second_quot[TIME_W-1:0];
      end
   end

   mtl_divider u_first_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (first_sum_upd),
      .divisor  (first_hits_upd),
      .busy     (first_busy),
      .quotient (first_quot)
   );

   mtl_divider u_second_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (second_sum_upd),
      .divisor  (second_hits_upd),
      .busy     (second_busy),
      .quotient (second_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         calm_samples_ff <= CALM_SAMPLES_RESET;
         threshold_ff    <= THRESHOLD_RESET;
         timeout_ff      <= TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CALM_SAMPLES: calm_samples_ff <= csr_data[CALM_W-1:0];
            CSR_THRESHOLD:    threshold_ff    <= csr_data[BRIGHTNESS_BITS-1:0];
            CSR_TIMEOUT:      timeout_ff      <= csr_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CALM;
         calm_run_ff    <= '0;
         motion_time_ff <= '0;
         ref_bright_ff  <= '0;
         slot_ff        <= '0;
         first_sum_ff   <= '0;
         second_sum_ff  <= '0;
         first_hits_ff  <= '0;
         second_hits_ff <= '0;
      end else if (cmd.step) begin
         phase_ff       <= phase_in;
         calm_run_ff    <= calm_run_in;
         motion_time_ff <= motion_time_in;
         ref_bright_ff  <= ref_bright_in;
         slot_ff        <= slot_in;
         first_sum_ff   <= first_sum_in;
         second_sum_ff  <= second_sum_in;
         first_hits_ff  <= first_hits_in;
         second_hits_ff <= second_hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_item;
      end
      pend_ff <= pend_in;
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.last_slot = last;
   assign status.div_busy  = first_busy || second_busy;
   assign rsp_item         = rsp_ff;

endmodule

// ===== hdl/mtl_ctrl.sv =====
// controller: sequences accept, state update, averaging and result hand-off
module mtl_ctrl import mtl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = status.last_slot ? ST_DIV : ST_PUSH;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.load_in = req_valid;
         end
         ST_STEP: begin
            cmd.step      = 1'b1;
            cmd.div_start = status.last_slot;
         end
         ST_DIV: begin
         end
         ST_PUSH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/motion_to_light_latency_meter.sv =====
// top level of the motion to light latency meter
//
// req channel: one sensor sample per item (motion flag, brightness, microsecond
// timestamp), taken when req_valid is high and req_stall is low.
// rsp channel: exactly one result item per sample, in order, held in an output
// register until taken (rsp_valid high, rsp_stall low).
// csr channel: register writes by index (calm samples, brightness threshold,
// timeout); csr_ready is always high, writes beyond the list are ignored.
// path: an accepted sample passes the input register, the state update step and the
// output register; the sample that fills the last slot also runs two serial dividers,
// one quotient bit per cycle over 35 bits, before its result is pushed.
// pacing: a new sample is taken only once the previous one has been through the
// state update and divider sequencing, one item at a time.
// a new sample is taken while the previous result still waits in the output
// register; if the receiver keeps stalling, the next result waits in the
// datapath and req_stall stays high until the output register frees.
// reset: synchronous, clears phase, counters, sums and restores register defaults
module motion_to_light_latency_meter import mtl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   mtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mtl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_item  (req_item),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== tb/sv/motion_to_light_latency_meter_test.sv =====
// testbench for the motion to light latency meter: directed and random sensor samples checked against a predictor
`timescale 1ns / 1ps

module motion_to_light_latency_meter_test import mtl_pkg::*; ();

   localparam int BMAX = (1 << BRIGHTNESS_BITS) - 1;
   localparam int SETTLE_CYCLES = 60;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {
      END_HIT     = 0,
      END_TIMEOUT = 1,
      END_HOLD    = 2
   } ending_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_item_type           req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor configuration and state
   logic [CALM_W-1:0]          cfg_calm = CALM_SAMPLES_RESET;
   logic [BRIGHTNESS_BITS-1:0] cfg_threshold = THRESHOLD_RESET;
   logic [TIME_W-1:0]          cfg_timeout = TIMEOUT_RESET;
   phase_type                  meter_phase = PH_CALM;
   logic [CALM_W-1:0]          calm_count = '0;
   logic [TIME_W-1:0]          motion_stamp = '0;
   logic [BRIGHTNESS_BITS-1:0] onset_bright = '0;
   int                         slot_num = 0;
   longint unsigned            even_sum = 0;
   longint unsigned            odd_sum = 0;
   int unsigned                even_hits = 0;
   int unsigned                odd_hits = 0;

   rsp_item_type pending_readings[$];

   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   bit force_max_elapsed = 1'b0;
   int stall_left = 0;

   int errors = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int onset_count = 0;
   int timeout_count = 0;
   int average_reports = 0;
   int empty_reports = 0;
   int register_writes = 0;

   motion_to_light_latency_meter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap(bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic rsp_item_type advance_meter(req_item_type s);
      rsp_item_type               r;
      logic [TIME_W-1:0]          elapsed;
      logic [BRIGHTNESS_BITS-1:0] diff;
      bit                         record;
      r = '0;
      record = 1'b0;
      case (meter_phase)
         PH_CALM: begin
            if (s.is_moving) begin
               calm_count = '0;
            end else begin
               calm_count = calm_count + 1'b1;
               if (calm_count >= cfg_calm) begin
                  meter_phase = PH_AWAIT_MOTION;
                  calm_count = '0;
               end
            end
         end
         PH_AWAIT_MOTION: begin
            if (s.is_moving) begin
               motion_stamp = s.time_us;
               onset_bright = s.brightness;
               meter_phase = PH_AWAIT_BRIGHT;
            end
         end
         PH_AWAIT_BRIGHT: begin
            elapsed = s.time_us - motion_stamp;
            diff = (s.brightness >= onset_bright) ? s.brightness - onset_bright
                                                  : onset_bright - s.brightness;
            if (diff > cfg_threshold) begin
               r.latency_valid = 1'b1;
               r.latency_us = elapsed;
               record = 1'b1;
               onset_count++;
            end else if (elapsed > cfg_timeout) begin
               r.timed_out = 1'b1;
               record = 1'b1;
               timeout_count++;
            end
            if (record) begin
               if (slot_num % 2 == 0) begin
                  even_sum += r.latency_us;
                  even_hits += r.latency_valid;
               end else begin
                  odd_sum += r.latency_us;
                  odd_hits += r.latency_valid;
               end
               meter_phase = PH_CALM;
               slot_num++;
               if (slot_num >= SLOTS) begin
                  r.averages_valid = 1'b1;
                  r.first_empty = (even_hits == 0);
                  r.second_empty = (odd_hits == 0);
                  r.first_average_us = (even_hits == 0) ? '0 : TIME_W'(even_sum / even_hits);
                  r.second_average_us = (odd_hits == 0) ? '0 : TIME_W'(odd_sum / odd_hits);
                  average_reports++;
                  if (r.first_empty || r.second_empty) empty_reports++;
                  slot_num = 0;
                  even_sum = 0;
                  odd_sum = 0;
                  even_hits = 0;
                  odd_hits = 0;
               end
            end
         end
         default: begin
            meter_phase = PH_CALM;
         end
      endcase
      r.phase = meter_phase;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      errors++;
      if (errors <= 40)
         $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic check_reading(rsp_item_type got);
      rsp_item_type want;
      if (pending_readings.size() == 0) begin
         report_mismatch("item with nothing expected", got.phase, '0);
         return;
      end
      want = pending_readings.pop_front();
      results_checked++;
      if (got.phase !== want.phase)
         report_mismatch("phase", got.phase, want.phase);
      if (got.latency_valid !== want.latency_valid)
         report_mismatch("latency_valid", got.latency_valid, want.latency_valid);
      if (got.timed_out !== want.timed_out)
         report_mismatch("timed_out", got.timed_out, want.timed_out);
      if (got.latency_us !== want.latency_us)
         report_mismatch("latency_us", got.latency_us, want.latency_us);
      if (got.averages_valid !== want.averages_valid)
         report_mismatch("averages_valid", got.averages_valid, want.averages_valid);
      if (got.first_average_us !== want.first_average_us)
         report_mismatch("first_average_us", got.first_average_us, want.first_average_us);
      if (got.second_average_us !== want.second_average_us)
         report_mismatch("second_average_us", got.second_average_us, want.second_average_us);
      if (got.first_empty !== want.first_empty)
         report_mismatch("first_empty", got.first_empty, want.first_empty);
      if (got.second_empty !== want.second_empty)
         report_mismatch("second_empty", got.second_empty, want.second_empty);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_reading(rsp_item);
      if (stall_left == 0) stall_left = pick_gap(rsp_idle_on);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_sample(req_item_type s);
      int gap;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= s;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      pending_readings.push_back(advance_meter(s));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      register_writes++;
      case (idx)
         CSR_CALM_SAMPLES: cfg_calm = data[CALM_W-1:0];
         CSR_THRESHOLD:    cfg_threshold = data[BRIGHTNESS_BITS-1:0];
         CSR_TIMEOUT:      cfg_timeout = data[TIME_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [CALM_W-1:0] calm, logic [BRIGHTNESS_BITS-1:0] thr,
                                logic [TIME_W-1:0] timeout);
      wait_idle();
      write_reg(CSR_CALM_SAMPLES, {(CSR_DATA_W-CALM_W)'($urandom), calm});
      write_reg(CSR_THRESHOLD, {(CSR_DATA_W-BRIGHTNESS_BITS)'($urandom), thr});
      write_reg(CSR_TIMEOUT, timeout);
   endtask

   function automatic req_item_type make_sample(bit mv, int b, logic [TIME_W-1:0] t);
      req_item_type s;
      s.is_moving = mv;
      s.brightness = BRIGHTNESS_BITS'(b);
      s.time_us = t;
      return s;
   endfunction

   // sample for the await brightness phase aimed at the given ending
   function automatic req_item_type make_ending(ending_type kind);
      req_item_type      s;
      int                ref_b, thr, lo, hi;
      logic [TIME_W-1:0] elapsed;
      longint unsigned   span;
      ref_b = onset_bright;
      thr = cfg_threshold;
      lo = (ref_b > thr) ? ref_b - thr : 0;
      hi = (ref_b + thr < BMAX) ? ref_b + thr : BMAX;
      s.is_moving = 1'($urandom_range(0, 1));
      if (kind == END_HIT && hi < BMAX && (lo == 0 || $urandom_range(0, 1) == 1)) begin
         s.brightness = BRIGHTNESS_BITS'($urandom_range(hi + 1, BMAX));
      end else if (kind == END_HIT && lo > 0) begin
         s.brightness = BRIGHTNESS_BITS'($urandom_range(0, lo - 1));
      end else begin
         if (kind == END_HIT) kind = END_TIMEOUT;
         case ($urandom_range(0, 4))
            0: s.brightness = BRIGHTNESS_BITS'(lo);
            1: s.brightness = BRIGHTNESS_BITS'(hi);
            default: s.brightness = BRIGHTNESS_BITS'($urandom_range(lo, hi));
         endcase
      end
      case (kind)
         END_HIT: begin
            case ($urandom_range(0, 3))
               0: elapsed = $urandom;
               1: elapsed = cfg_timeout + TIME_W'($urandom_range(1, 100));
               default: elapsed = $urandom_range(0, 5000);
            endcase
         end
         END_TIMEOUT: begin
            if (cfg_timeout == '1) begin
               elapsed = $urandom;
            end else begin
               span = 64'hFFFF_FFFF - cfg_timeout;
               if ($urandom_range(0, 3) == 0)
                  elapsed = TIME_W'(cfg_timeout + 1 + ($urandom % span));
               else
                  elapsed = TIME_W'(cfg_timeout + 1 + ($urandom_range(0, 99) % span));
            end
         end
         default: begin
            if ($urandom_range(0, 4) == 0)
               elapsed = cfg_timeout;
            else
               elapsed = $urandom_range(0, (cfg_timeout < 3000) ? cfg_timeout : 3000);
         end
      endcase
      if (force_max_elapsed) elapsed = '1;
      s.time_us = motion_stamp + elapsed;
      return s;
   endfunction

   function automatic req_item_type next_sample();
      req_item_type s;
      ending_type   kind;
      int           roll;
      roll = $urandom_range(0, 99);
      s.brightness = BRIGHTNESS_BITS'($urandom_range(0, BMAX));
      s.time_us = $urandom;
      s.is_moving = 1'b0;
      case (meter_phase)
         PH_CALM: s.is_moving = (roll < ((cfg_calm > 8) ? 1 : 8));
         PH_AWAIT_MOTION: s.is_moving = (roll < 60);
         default: begin
            if (roll < 40) kind = END_HIT;
            else if (roll < 65) kind = END_TIMEOUT;
            else kind = END_HOLD;
            s = make_ending(kind);
         end
      endcase
      return s;
   endfunction

   task automatic run_measurement(ending_type kind);
      while (meter_phase != PH_AWAIT_BRIGHT)
         send_sample(make_sample(meter_phase == PH_AWAIT_MOTION, $urandom_range(0, BMAX),
                                 $urandom));
      while (meter_phase == PH_AWAIT_BRIGHT) send_sample(make_ending(kind));
   endtask

   task automatic run_phase(logic [CALM_W-1:0] calm, logic [BRIGHTNESS_BITS-1:0] thr,
                            logic [TIME_W-1:0] timeout, int items, bit idling);
      apply_setting(calm, thr, timeout);
      req_idle_on = idling;
      rsp_idle_on = idling;
      repeat (items) send_sample(next_sample());
   endtask

   // calm counting under the reset settings, moving samples clear the run
   task automatic test_reset_calm();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_sample(make_sample(1'b0, 0, 32'h0000_0000));
      send_sample(make_sample(1'b0, BMAX, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b1, BMAX, 32'h0000_0000));
      send_sample(make_sample(1'b0, 0, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b1, 512, 32'h5555_5555));
      send_sample(make_sample(1'b0, 341, 32'hAAAA_AAAA));
   endtask

   task automatic test_edge_cases();
      // zero calm limit arms after one still item
      apply_setting(8'd0, 10'd3, 32'd1000);
      send_sample(make_sample(1'b0, 0, 32'd0));
      // motion just before the timestamp wraps
      send_sample(make_sample(1'b1, 512, 32'hFFFF_FFF0));
      send_sample(make_sample(1'b0, 515, 32'hFFFF_FFF0 + 32'd1000));
      send_sample(make_sample(1'b1, 509, 32'hFFFF_FFF0 + 32'd1001));
      // onset wins over an expired timeout
      send_sample(make_sample(1'b0, 100, 32'd1));
      send_sample(make_sample(1'b1, BMAX, 32'd0));
      send_sample(make_sample(1'b0, 0, 32'd5000));
      // zero latency onset, brightness going up
      send_sample(make_sample(1'b0, 7, 32'd2));
      send_sample(make_sample(1'b1, 0, 32'd7));
      send_sample(make_sample(1'b1, 4, 32'd7));
      // largest threshold and zero timeout
      apply_setting(8'd0, 10'd1023, 32'd0);
      send_sample(make_sample(1'b0, 0, 32'd50));
      send_sample(make_sample(1'b1, 0, 32'd100));
      send_sample(make_sample(1'b0, BMAX, 32'd100));
      send_sample(make_sample(1'b0, BMAX, 32'd101));
   endtask

   // slot parity, empty halves and the widest sums
   task automatic test_slot_rounds();
      apply_setting(8'd1, 10'd10, 32'd50);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      while (slot_num != 0) run_measurement(ending_type'($urandom_range(0, 1)));
      repeat (SLOTS) run_measurement(ending_type'(slot_num % 2));
      repeat (SLOTS) run_measurement(END_TIMEOUT);
      repeat (SLOTS) run_measurement(ending_type'(1 - slot_num % 2));
      apply_setting(8'd1, 10'd10, '1);
      force_max_elapsed = 1'b1;
      repeat (SLOTS) run_measurement(END_HIT);
      force_max_elapsed = 1'b0;
   endtask

   task automatic test_unused_register();
      wait_idle();
      write_reg(CSR_UNUSED, '1);
      repeat (25) send_sample(next_sample());
   endtask

   task automatic test_random_phases();
      logic [TIME_W-1:0] timeout;
      run_phase(CALM_SAMPLES_RESET, THRESHOLD_RESET, TIMEOUT_RESET, 80, 1'b1);
      run_phase(8'd255, 10'd1023, '1, 30, 1'b0);
      run_phase(8'd1, 10'd0, 32'd0, 80, 1'b0);
      run_phase(8'd2, 10'd1023, 32'd500, 60, 1'b1);
      repeat (2) begin
         case ($urandom_range(0, 2))
            0: timeout = $urandom_range(0, 2000);
            1: timeout = $urandom;
            default: timeout = '1;
         endcase
         run_phase(CALM_W'($urandom_range(1, 4)), BRIGHTNESS_BITS'($urandom_range(0, 300)),
                   timeout, 60, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_calm();
      test_edge_cases();
      test_slot_rounds();
      test_unused_register();
      test_random_phases();
      wait_idle();
      $display("covered %0d samples, %0d results checked, %0d onsets, %0d timeouts",
               samples_sent, results_checked, onset_count, timeout_count);
      $display("%0d average reports (%0d with an empty half), %0d register writes",
               average_reports, empty_reports, register_writes);
      if (errors == 0)
         $display("motion_to_light_latency_meter_test OK");
      else
         $display("motion_to_light_latency_meter_test NOT OK");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results still expected", pending_readings.size());
      $display("motion_to_light_latency_meter_test NOT OK");
      $finish;
   end

endmodule
